FILE: hdl/fltpm_pkg.sv
// Shared types and constants for the four-level page table mapper.
package fltpm_pkg;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENTRY_W = 43;
  localparam int FRAME_W = 40;
  localparam int IDX_W   = 9;
  localparam int OFS_W   = 12;
  localparam int PAGES_W = PA_W - OFS_W;
  localparam int ENTRIES_PER_TABLE = 512;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_XLAT  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_BAD,
    RES_OOT,
    RES_HIT,
    RES_MISS
  } res_t;

  typedef struct packed {
    logic  clr;
    logic  load;
    logic  start;
    logic  alloc;
    logic  follow;
    logic  write_leaf;
    logic  next_page;
    res_t  res;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  chk_bad;
    logic  chk_empty;
    logic  lvl_last;
    logic  entry_zero;
    logic  pool_empty;
    logic  pages_last;
    kind_t kind;
    logic  out_free;
  } sts_t;
endpackage

FILE: hdl/fltpm_ram.sv
// Generic single-port RAM with registered read.
module fltpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

FILE: hdl/fltpm_ctrl.sv
// Controller state machine for the page table mapper.
module fltpm_ctrl import fltpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_READ, S_EVAL, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.res = RES_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.kind == KIND_MAP || sts.kind == KIND_XLAT) begin
          state_nxt = S_READ;
        end else if (sts.chk_bad) begin
          cmd.res = RES_BAD;
          state_nxt = S_DONE;
        end else if (sts.chk_empty) begin
          cmd.res = RES_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.lvl_last) begin
          if (!sts.entry_zero) begin
            cmd.follow = 1'b1;
            state_nxt = S_READ;
          end else if (sts.kind == KIND_XLAT) begin
            cmd.res = RES_MISS;
            state_nxt = S_DONE;
          end else if (sts.pool_empty) begin
            cmd.res = RES_OOT;
            state_nxt = S_DONE;
          end else begin
            cmd.alloc = 1'b1;
            state_nxt = S_READ;
          end
        end else if (sts.kind == KIND_XLAT) begin
          cmd.res = RES_HIT;
          state_nxt = S_DONE;
        end else begin
          cmd.write_leaf = 1'b1;
          if (sts.kind == KIND_MAP || sts.pages_last) begin
            cmd.res = RES_OK;
            state_nxt = S_DONE;
          end else begin
            cmd.next_page = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end
endmodule

FILE: hdl/fltpm_dp.sv
// Datapath: table store, walk registers and result register.
module fltpm_dp import fltpm_pkg::*; #(
  parameter int TABLE_POOL = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        in_kind,
  input  logic [VA_W-1:0]   in_virtual_address,
  input  logic [PA_W-1:0]   in_physical_address,
  input  logic [PA_W-1:0]   in_end_address,
  input  logic [2:0]        in_page_flags,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_found,
  output logic [PA_W-1:0]   out_translated_address,
  output logic              out_leaf_present,
  output logic              out_leaf_writable,
  output logic              out_leaf_user,
  output logic              out_replaced_mapping
);
  localparam int DEPTH = TABLE_POOL * ENTRIES_PER_TABLE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(TABLE_POOL);
  localparam int NW    = $clog2(TABLE_POOL + 1);

  kind_t              kind_r;
  logic [VA_W-1:0]    va_r;
  logic [PA_W-1:0]    pa_r, pend_r;
  logic [2:0]         flags_r;
  logic [PAGES_W-1:0] pages_r;
  logic [TW-1:0]      table_r;
  logic [1:0]         level_r;
  logic [NW-1:0]      next_free_r;
  logic               replaced_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [1:0]         res_status_r;
  logic               res_found_r;
  logic [PA_W-1:0]    res_xlat_r;
  logic [2:0]         res_flags_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_found_r;
  logic [PA_W-1:0]    out_xlat_r;
  logic [2:0]         out_flags_r;
  logic               out_repl_r;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    case (level_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign ram_addr = cmd.clr ? clr_cnt_r : AW'({table_r, idx});
  assign ram_we   = cmd.clr | cmd.alloc | cmd.write_leaf;

  always_comb begin
    if (cmd.alloc) begin
      ram_wdata = {FRAME_W'(next_free_r[TW-1:0]), 3'b111};
    end else if (cmd.write_leaf) begin
      ram_wdata = {pa_r[PA_W-1:OFS_W], flags_r};
    end else begin
      ram_wdata = '0;
    end
  end

  fltpm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.clr_last   = (clr_cnt_r == AW'(DEPTH - 1));
    sts.chk_bad    = (kind_r == KIND_RSVD) || (va_r[OFS_W-1:0] != '0) ||
                     (pa_r[OFS_W-1:0] != '0) || (pend_r[OFS_W-1:0] != '0) ||
                     (pend_r < pa_r);
    sts.chk_empty  = (pend_r[PA_W-1:OFS_W] == pa_r[PA_W-1:OFS_W]);
    sts.lvl_last   = (level_r == 2'd3);
    sts.entry_zero = (ram_rdata == '0);
    sts.pool_empty = (next_free_r >= NW'(TABLE_POOL));
    sts.pages_last = (pages_r == PAGES_W'(1));
    sts.kind       = kind_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      next_free_r <= NW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.alloc) next_free_r <= next_free_r + NW'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= kind_t'(in_kind);
      va_r       <= in_virtual_address;
      pa_r       <= in_physical_address;
      pend_r     <= in_end_address;
      flags_r    <= in_page_flags;
      table_r    <= '0;
      level_r    <= '0;
      replaced_r <= 1'b0;
    end
    if (cmd.start) pages_r <= pend_r[PA_W-1:OFS_W] - pa_r[PA_W-1:OFS_W];
    if (cmd.alloc) begin
      table_r <= next_free_r[TW-1:0];
      level_r <= level_r + 2'd1;
    end
    if (cmd.follow) begin
      table_r <= ram_rdata[3 +: TW];
      level_r <= level_r + 2'd1;
    end
    if (cmd.write_leaf && ram_rdata != '0) replaced_r <= 1'b1;
    if (cmd.next_page) begin
      va_r    <= va_r + VA_W'(4096);
      pa_r    <= pa_r + PA_W'(4096);
      pages_r <= pages_r - PAGES_W'(1);
      table_r <= '0;
      level_r <= '0;
    end
    case (cmd.res)
      RES_OK, RES_BAD, RES_OOT, RES_MISS: begin
        res_status_r <= (cmd.res == RES_BAD) ? ST_BAD :
                        (cmd.res == RES_OOT) ? ST_OOT : ST_OK;
        res_found_r  <= 1'b0;
        res_xlat_r   <= '0;
        res_flags_r  <= '0;
      end
      RES_HIT: begin
        res_status_r <= ST_OK;
        res_found_r  <= 1'b1;
        res_xlat_r   <= {ram_rdata[ENTRY_W-1:3], va_r[OFS_W-1:0]};
        res_flags_r  <= ram_rdata[2:0];
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_xlat_r   <= res_xlat_r;
      out_flags_r  <= res_flags_r;
      out_repl_r   <= replaced_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_found              = out_found_r;
  assign out_translated_address = out_xlat_r;
  assign out_leaf_present       = out_flags_r[0];
  assign out_leaf_writable      = out_flags_r[1];
  assign out_leaf_user          = out_flags_r[2];
  assign out_replaced_mapping   = out_repl_r;
endmodule

FILE: hdl/four_level_page_table_mapper.sv
// Top level: four-level page table mapper (controller plus datapath).
// Each level is read in S_READ and evaluated in S_EVAL through the
//   single table store port; an item also passes accept, check and result.
// Range items are walked page by page; one item is in work at a time.
// Reset: synchronous, active low; a clearing pass over all TABLE_POOL*512
//   entries zeroes the table store while in_stall stays high.
module four_level_page_table_mapper import fltpm_pkg::*; #(
  parameter int TABLE_POOL = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_kind,
  input  logic [VA_W-1:0] in_virtual_address,
  input  logic [PA_W-1:0] in_physical_address,
  input  logic [PA_W-1:0] in_end_address,
  input  logic [2:0]      in_page_flags,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic            out_found,
  output logic [PA_W-1:0] out_translated_address,
  output logic            out_leaf_present,
  output logic            out_leaf_writable,
  output logic            out_leaf_user,
  output logic            out_replaced_mapping
);
  cmd_t cmd;
  sts_t sts;
  cmd_t cmd_fix;

  fltpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fltpm_dp #(.TABLE_POOL(TABLE_POOL)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd_fix),
    .sts                    (sts),
    .in_kind                (in_kind),
    .in_virtual_address     (in_virtual_address),
    .in_physical_address    (in_physical_address),
    .in_end_address         (in_end_address),
    .in_page_flags          (in_page_flags),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_found              (out_found),
    .out_translated_address (out_translated_address),
    .out_leaf_present       (out_leaf_present),
    .out_leaf_writable      (out_leaf_writable),
    .out_leaf_user          (out_leaf_user),
    .out_replaced_mapping   (out_replaced_mapping)
  );

  assign cmd_fix = cmd;
endmodule
